### rtl/core/hlm_pkg.sv
// Shared types, constants and table reset values of the heartbeat lateness monitor.
package hlm_pkg;

  localparam int Slots       = 16;
  localparam int IdxW        = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int MaxResults  = 16;
  localparam int ResCntW     = $clog2(MaxResults + 1);
  localparam int InitCount   = 9;
  localparam logic [15:0] SlackReset = 16'd30;

  localparam logic [15:0] InitPeriods [InitCount] = '{
    16'd100, 16'd200, 16'd250, 16'd250, 16'd120, 16'd40, 16'd10, 16'd10, 16'd1000
  };

  typedef enum logic [1:0] {
    CmdPing      = 2'd0,
    CmdReport    = 2'd1,
    CmdSetPeriod = 2'd2
  } hlm_cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [31:0] now_ms;
    logic [15:0] period_value;
  } hlm_in_t;

  typedef struct packed {
    logic [3:0]  late_slot;
    logic [31:0] age_ms;
    logic [31:0] lap_ms;
    logic [15:0] slot_period;
    logic        none_late;
    logic        last;
  } hlm_out_t;

  typedef struct packed {
    logic            ping_we;
    logic            per_we;
    logic [IdxW-1:0] addr;
    logic [63:0]     ping_row;
    logic [15:0]     period;
  } hlm_wr_t;

  typedef struct packed {
    logic [31:0] last_ping;
    logic [31:0] prev_ping;
    logic [15:0] period;
  } hlm_rd_t;

  function automatic logic [15:0] init_period(input logic [IdxW-1:0] idx);
    logic [15:0] val;
    val = 16'd0;
    for (int k = 0; k < InitCount; k++) begin
      if (int'(idx) == k) begin
        val = InitPeriods[k];
      end
    end
    return val;
  endfunction

endpackage

### rtl/core/hlm_ifs.sv
// Valid/ready channel interfaces for command, result and slack words.
interface hlm_in_if import hlm_pkg::*; ();
  logic    valid;
  logic    ready;
  hlm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlm_out_if import hlm_pkg::*; ();
  logic     valid;
  logic     ready;
  hlm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlm_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/hlm_slot_mem.sv
// Slot table memories: ping times row and period word, registered read.
module hlm_slot_mem import hlm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] rd_addr_i,
  input  hlm_wr_t         wr_i,
  output hlm_rd_t         rd_o
);

  logic [63:0] ping_mem [Slots];
  logic [15:0] per_mem  [Slots];
  logic [Slots-1:0] ping_vld_q;
  logic [Slots-1:0] per_vld_q;
  logic [63:0]      ping_rd_q;
  logic [15:0]      per_rd_q;
  logic             ping_rd_vld_q;
  logic             per_rd_vld_q;
  logic [IdxW-1:0]  rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.ping_we) begin
      ping_mem[wr_i.addr] <= wr_i.ping_row;
    end
    if (wr_i.per_we) begin
      per_mem[wr_i.addr] <= wr_i.period;
    end
    ping_rd_q <= ping_mem[rd_addr_i];
    per_rd_q  <= per_mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_vld_q    <= '0;
      per_vld_q     <= '0;
      ping_rd_vld_q <= 1'b0;
      per_rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.ping_we) begin
        ping_vld_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.per_we) begin
        per_vld_q[wr_i.addr] <= 1'b1;
      end
      ping_rd_vld_q <= ping_vld_q[rd_addr_i];
      per_rd_vld_q  <= per_vld_q[rd_addr_i];
    end
  end

  assign rd_o.last_ping = ping_rd_vld_q ? ping_rd_q[63:32] : 32'd0;
  assign rd_o.prev_ping = ping_rd_vld_q ? ping_rd_q[31:0]  : 32'd0;
  assign rd_o.period    = per_rd_vld_q  ? per_rd_q : init_period(rd_addr_q);

endmodule

### rtl/core/heartbeat_lateness_monitor_core.sv
// Heartbeat lateness monitor top level: command decode, report walk and result register.
//
//   channel | dir | word
//   cfg_i   | in  | slack_ms
//   in_i    | in  | command, slot, now_ms, period_value
//   out_o   | out | late_slot, age_ms, lap_ms, slot_period, none_late, last
//
// Ping reads the table, then writes back in StPing; set period and unused codes stay in idle.
// Report walks one slot per cycle off the table read port unless stalled, then a flush.
// A full result register stalls the walk; the next word is taken while a result waits.
// Reset clears valid bits of the table at once; no clearing pass.
module heartbeat_lateness_monitor_core import hlm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlm_cfg_if.sink   cfg_i,
  hlm_in_if.sink    in_i,
  hlm_out_if.source out_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPing  = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [15:0]        slack_q;
  logic [31:0]        now_q;
  logic [IdxW-1:0]    slot_q;
  logic               slot_ok_q;
  logic [IdxW-1:0]    walk_idx_q, walk_idx_d;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic               pend_vld_q, pend_vld_d;
  hlm_out_t           pend_q, pend_d;
  logic               out_vld_q, out_vld_d;
  hlm_out_t           out_q, out_d;

  logic            in_fire;
  logic            in_slot_ok;
  logic [IdxW-1:0] rd_addr;
  hlm_wr_t         wr;
  hlm_rd_t         rd;
  logic [31:0]     age;
  logic [31:0]     lap;
  logic [16:0]     limit;
  logic            hit;
  logic            need_push;
  logic            out_free;
  logic            stall;
  logic            end_walk;

  hlm_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_slot_ok  = int'(in_i.data.slot) < Slots;
  assign out_free    = !out_vld_q || out_o.ready;

  assign age   = now_q - rd.last_ping;
  assign lap   = rd.last_ping - rd.prev_ping;
  assign limit = 17'(rd.period) + 17'(slack_q);
  assign hit   = (state_q == StWalk) && (rd.last_ping != 32'd0) &&
                 ((age > 32'(limit)) || (lap > 32'(limit)));
  assign need_push = hit && pend_vld_q;
  assign stall     = need_push && !out_free;
  assign end_walk  = (walk_idx_q == IdxW'(Slots - 1)) ||
                     (hit && (res_cnt_q == ResCntW'(MaxResults - 1)));

  always_comb begin
    wr.ping_we  = (state_q == StPing) && slot_ok_q;
    wr.per_we   = in_fire && (in_i.data.command == CmdSetPeriod) && in_slot_ok;
    wr.addr     = (state_q == StPing) ? slot_q : IdxW'(in_i.data.slot);
    wr.ping_row = {now_q, rd.last_ping};
    wr.period   = in_i.data.period_value;
  end

  always_comb begin
    unique case (state_q)
      StIdle:  rd_addr = (in_i.data.command == CmdReport) ? '0 : IdxW'(in_i.data.slot);
      StWalk:  rd_addr = stall ? walk_idx_q : walk_idx_q + 1'b1;
      default: rd_addr = walk_idx_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    walk_idx_d = walk_idx_q;
    res_cnt_d  = res_cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          priority case (in_i.data.command)
            CmdPing: begin
              state_d = StPing;
            end
            CmdReport: begin
              state_d    = StWalk;
              walk_idx_d = '0;
              res_cnt_d  = '0;
              pend_vld_d = 1'b0;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StPing: begin
        state_d = StIdle;
      end
      StWalk: begin
        if (!stall) begin
          if (hit) begin
            pend_vld_d            = 1'b1;
            pend_d.late_slot      = 4'(walk_idx_q);
            pend_d.age_ms         = age;
            pend_d.lap_ms         = lap;
            pend_d.slot_period    = rd.period;
            pend_d.none_late      = 1'b0;
            pend_d.last           = 1'b0;
            res_cnt_d             = res_cnt_q + 1'b1;
          end
          if (need_push) begin
            out_vld_d = 1'b1;
            out_d     = pend_q;
          end
          if (end_walk) begin
            state_d = StFlush;
          end else begin
            walk_idx_d = walk_idx_q + 1'b1;
          end
        end
      end
      default: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d           = '0;
            out_d.none_late = 1'b1;
            out_d.last      = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      slack_q    <= SlackReset;
      walk_idx_q <= '0;
      res_cnt_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      walk_idx_q <= walk_idx_d;
      res_cnt_q  <= res_cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        slack_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (in_fire) begin
      now_q     <= in_i.data.now_ms;
      slot_q    <= IdxW'(in_i.data.slot);
      slot_ok_q <= in_slot_ok;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (res_cnt_q != '0))
    else $error("pending result without a result count");

  a_walk_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && !stall && !end_walk) |=>
      (state_q == StWalk && walk_idx_q == $past(walk_idx_q) + 1'b1))
    else $error("walk index did not advance");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.none_late) |-> out_q.last)
    else $error("none result not final");

  a_walk_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && stall) |=> (state_q == StWalk && $stable(walk_idx_q)))
    else $error("walk moved during stall");
`endif

endmodule

### tb/tb.sv
// Testbench for the heartbeat lateness monitor: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb;
  import hlm_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hlm_in_if  in_if ();
  hlm_out_if out_if ();
  hlm_cfg_if cfg_if ();

  heartbeat_lateness_monitor_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hlm_in_t     pending [$];
  hlm_out_t    lateness_q [$];
  logic [31:0] ping_last [Slots];
  logic [31:0] ping_prev [Slots];
  logic [15:0] period_of [Slots];
  logic [15:0] slack_now;
  logic [31:0] tick;
  logic        word_taken = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int          errors = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic hlm_in_t cmd_word(input logic [1:0] cmd, input logic [3:0] slot,
                                       input logic [31:0] now, input logic [15:0] pval);
    hlm_in_t w;
    w.command      = cmd;
    w.slot         = slot;
    w.now_ms       = now;
    w.period_value = pval;
    return w;
  endfunction

  task automatic judge_word(input hlm_in_t w);
    hlm_out_t    held;
    logic        have;
    logic [31:0] age;
    logic [31:0] lap;
    logic [16:0] lim;
    have = 1'b0;
    held = '0;
    case (w.command)
      CmdPing: begin
        ping_prev[w.slot] = ping_last[w.slot];
        ping_last[w.slot] = w.now_ms;
      end
      CmdSetPeriod: begin
        period_of[w.slot] = w.period_value;
      end
      CmdReport: begin
        for (int i = 0; i < Slots; i++) begin
          if (ping_last[i] != 32'd0) begin
            age = w.now_ms - ping_last[i];
            lap = ping_last[i] - ping_prev[i];
            lim = 17'(period_of[i]) + 17'(slack_now);
            if (age > 32'(lim) || lap > 32'(lim)) begin
              if (have) begin
                lateness_q.push_back(held);
              end
              held = '0;
              held.late_slot   = 4'(i);
              held.age_ms      = age;
              held.lap_ms      = lap;
              held.slot_period = period_of[i];
              have = 1'b1;
            end
          end
        end
        if (!have) begin
          held.none_late = 1'b1;
        end
        held.last = 1'b1;
        lateness_q.push_back(held);
      end
      default: begin
      end
    endcase
  endtask

  // sender: advance to the next word once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || word_taken) begin
      if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_if.data  <= pending.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && hold_cnt == 0 && $urandom_range(99) >= rx_stall_pct;
  end

  // long receiver hold
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HoldCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin : watch
    hlm_out_t want;
    word_taken = in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (word_taken) begin
        judge_word(in_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        if (lateness_q.size() == 0) begin
          $error("unexpected result word: late_slot %0d none_late %0b",
                 out_if.data.late_slot, out_if.data.none_late);
          errors++;
        end else begin
          want = lateness_q.pop_front();
          if (out_if.data.late_slot !== want.late_slot) begin
            $error("late_slot: expected %0d, got %0d", want.late_slot, out_if.data.late_slot);
            errors++;
          end
          if (out_if.data.age_ms !== want.age_ms) begin
            $error("age_ms: expected %0d, got %0d", want.age_ms, out_if.data.age_ms);
            errors++;
          end
          if (out_if.data.lap_ms !== want.lap_ms) begin
            $error("lap_ms: expected %0d, got %0d", want.lap_ms, out_if.data.lap_ms);
            errors++;
          end
          if (out_if.data.slot_period !== want.slot_period) begin
            $error("slot_period: expected %0d, got %0d", want.slot_period,
                   out_if.data.slot_period);
            errors++;
          end
          if (out_if.data.none_late !== want.none_late) begin
            $error("none_late: expected %0b, got %0b", want.none_late, out_if.data.none_late);
            errors++;
          end
          if (out_if.data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.data.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending.size() != 0 || in_if.valid || lateness_q.size() != 0);
    repeat (Slots + 4) @(posedge clk_i);
    #1;
  endtask

  task automatic write_slack(input logic [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    slack_now = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    #1;
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    hlm_in_t w;
    int      pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      tick = tick + $urandom_range(400);
      if ($urandom_range(19) == 0) begin
        tick = tick + $urandom();
      end
      w = cmd_word(CmdUnused, 4'($urandom_range(15)), $urandom(), 16'($urandom()));
      if (pick < 50) begin
        w.command = CmdPing;
        w.now_ms  = tick;
      end else if (pick < 78) begin
        w.command = CmdReport;
        w.now_ms  = tick;
      end else if (pick < 94) begin
        w.command = CmdSetPeriod;
        if ($urandom_range(3) != 0) begin
          w.period_value = 16'($urandom_range(400));
        end
      end
      pending.push_back(w);
    end
    drain();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    tick         = 32'd0;
    slack_now    = SlackReset;
    for (int i = 0; i < Slots; i++) begin
      ping_last[i] = 32'd0;
      ping_prev[i] = 32'd0;
      period_of[i] = (i < InitCount) ? InitPeriods[i] : 16'd0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd1000, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd0, 32'd0, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'hFFFF_FFFF, 16'hFFFF));
    pending.push_back(cmd_word(CmdPing, 4'd0, 32'd100, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd0, 32'd200, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd330, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd331, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd1, 32'd1000, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd1, 32'd1230, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd1460, 16'd0));
    pending.push_back(cmd_word(CmdSetPeriod, 4'd0, 32'd0, 16'hFFFF));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd1460, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd1, 32'd1461, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'd1461, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd15, 32'hFFFF_FFF0, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd15, 32'h0000_0005, 16'd0));
    pending.push_back(cmd_word(CmdReport, 4'd0, 32'h0000_0010, 16'd0));
    pending.push_back(cmd_word(CmdUnused, 4'hF, 32'hFFFF_FFFF, 16'hFFFF));
    pending.push_back(cmd_word(CmdSetPeriod, 4'hF, 32'hFFFF_FFFF, 16'hFFFF));
    pending.push_back(cmd_word(CmdPing, 4'd8, 32'h8000_0000, 16'd0));
    pending.push_back(cmd_word(CmdPing, 4'd7, 32'hFFFF_FFFF, 16'hFFFF));
    pending.push_back(cmd_word(CmdReport, 4'hF, 32'h8000_0406, 16'hFFFF));
    drain();

    write_slack(16'd0);
    tick = $urandom();
    run_phase(0, 0, 15);

    write_slack(16'hFFFF);
    run_phase(65, 0, 15);

    write_slack(16'($urandom_range(500)));
    tick = 32'hFFFF_F000;
    run_phase(0, 65, 15);

    // fill the block behind a held-off receiver: every slot late on each report
    write_slack(16'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req++;
    for (int s = 0; s < Slots; s++) begin
      pending.push_back(cmd_word(CmdPing, 4'(s), 32'h0001_0000 + 32'(s), 16'd0));
    end
    repeat (6) pending.push_back(cmd_word(CmdReport, 4'd0, 32'h0100_0000, 16'd0));
    drain();

    write_slack(SlackReset);
    run_phase(13, 13, 15);

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
